// ----- sv/cfbc_pkg.sv -----
// ----------------------------------------------------------------------------
// cfbc_pkg
// Shared types, byte position codes and the CRC-16/XMODEM byte step for the
// command frame builder.
// ----------------------------------------------------------------------------
package cfbc_pkg;

   localparam int unsigned POS_W = 4;

   // Position of the byte being produced inside one input transaction.
   localparam logic [POS_W-1:0] POS_HDR0    = 4'd0;   // start byte
   localparam logic [POS_W-1:0] POS_HDR1    = 4'd1;   // length + 8
   localparam logic [POS_W-1:0] POS_HDR2    = 4'd2;
   localparam logic [POS_W-1:0] POS_HDR3    = 4'd3;
   localparam logic [POS_W-1:0] POS_HDR4    = 4'd4;
   localparam logic [POS_W-1:0] POS_HDR5    = 4'd5;   // first CRC-covered byte
   localparam logic [POS_W-1:0] POS_HDR6    = 4'd6;   // length
   localparam logic [POS_W-1:0] POS_HDR7    = 4'd7;   // flag high
   localparam logic [POS_W-1:0] POS_HDR8    = 4'd8;   // flag low
   localparam logic [POS_W-1:0] POS_PAYLOAD = 4'd9;
   localparam logic [POS_W-1:0] POS_CRC_HI  = 4'd10;
   localparam logic [POS_W-1:0] POS_CRC_LO  = 4'd11;

   localparam logic [7:0]  HDR_START  = 8'hFD;
   localparam logic [7:0]  HDR_FILL   = 8'hFF;
   localparam logic [7:0]  HDR_MARK   = 8'h7E;
   localparam logic [7:0]  HDR_ZERO   = 8'h00;
   localparam logic [7:0]  HDR_CMD    = 8'h08;
   localparam logic [7:0]  LEN_BIAS   = 8'h08;
   localparam logic [15:0] CRC_POLY   = 16'h1021;
   localparam logic [15:0] CRC_INIT   = 16'h0000;

   typedef struct packed {
      logic [7:0]  payload_byte;
      logic [7:0]  payload_length;
      logic [15:0] flag_word;
      logic        frame_last;
      logic        no_payload;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } rsp_type;

   // Sequencer outputs for the byte at the current position.
   typedef struct packed {
      logic [7:0]       out_byte;
      logic             crc_en;
      logic             last;
      logic             frame_end;
      logic [POS_W-1:0] next_pos;
   } seq_type;

   // One byte through CRC-16/XMODEM, MSB first.
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         fb = c[15] ^ b[7-k];
         c  = {c[14:0], 1'b0};
         if (fb) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage

// ----- sv/cfbc_byte_seq.sv -----
// ----------------------------------------------------------------------------
// cfbc_byte_seq
// Selects the frame byte for the current position of a transaction and works
// out the following position, the CRC coverage and the end marks.
// ----------------------------------------------------------------------------
module cfbc_byte_seq (
   input  logic [cfbc_pkg::POS_W-1:0] pos,
   input  cfbc_pkg::req_type          item,
   input  logic [15:0]                crc,
   output cfbc_pkg::seq_type          seq
);

   logic ends;

   always_comb begin
      ends = item.no_payload | item.frame_last;

      seq.crc_en    = pos inside {[cfbc_pkg::POS_HDR5 : cfbc_pkg::POS_PAYLOAD]};
      seq.frame_end = (pos == cfbc_pkg::POS_CRC_LO);
      seq.last      = (pos == cfbc_pkg::POS_CRC_LO) ||
                      ((pos == cfbc_pkg::POS_PAYLOAD) && !ends);

      case (pos)
         cfbc_pkg::POS_HDR0:    seq.out_byte = cfbc_pkg::HDR_START;
         cfbc_pkg::POS_HDR1:    seq.out_byte = item.payload_length + cfbc_pkg::LEN_BIAS;
         cfbc_pkg::POS_HDR2:    seq.out_byte = cfbc_pkg::HDR_FILL;
         cfbc_pkg::POS_HDR3:    seq.out_byte = cfbc_pkg::HDR_MARK;
         cfbc_pkg::POS_HDR4:    seq.out_byte = cfbc_pkg::HDR_ZERO;
         cfbc_pkg::POS_HDR5:    seq.out_byte = cfbc_pkg::HDR_CMD;
         cfbc_pkg::POS_HDR6:    seq.out_byte = item.payload_length;
         cfbc_pkg::POS_HDR7:    seq.out_byte = item.flag_word[15:8];
         cfbc_pkg::POS_HDR8:    seq.out_byte = item.flag_word[7:0];
         cfbc_pkg::POS_PAYLOAD: seq.out_byte = item.payload_byte;
         cfbc_pkg::POS_CRC_HI:  seq.out_byte = crc[15:8];
         cfbc_pkg::POS_CRC_LO:  seq.out_byte = crc[7:0];
         default:               seq.out_byte = cfbc_pkg::HDR_ZERO;
      endcase

      case (pos)
         cfbc_pkg::POS_HDR8:    seq.next_pos = item.no_payload ? cfbc_pkg::POS_CRC_HI
                                                               : cfbc_pkg::POS_PAYLOAD;
         cfbc_pkg::POS_PAYLOAD: seq.next_pos = cfbc_pkg::POS_CRC_HI;
         cfbc_pkg::POS_CRC_HI:  seq.next_pos = cfbc_pkg::POS_CRC_LO;
         cfbc_pkg::POS_CRC_LO:  seq.next_pos = cfbc_pkg::POS_HDR0;
         default:               seq.next_pos = pos + {{(cfbc_pkg::POS_W-1){1'b0}}, 1'b1};
      endcase
   end

endmodule

// ----- sv/command_frame_builder_crc16_core.sv -----
// ----------------------------------------------------------------------------
// command_frame_builder_crc16_core
// Turns a stream of payload byte transactions into framed commands: header,
// payload bytes and a trailing CRC-16/XMODEM, one output byte per unstalled cycle.
// ----------------------------------------------------------------------------
//  channel | ports                          | moves
//  --------+--------------------------------+----------------------------------
//  req     | req_valid, req_stall, req_data | one payload byte + frame control
//  rsp     | rsp_valid, rsp_stall, rsp_data | one frame byte with end marks
//
//  A transaction yields 1 to 12 output bytes, one per cycle while rsp does not
//  stall: 9 header bytes on the first transaction of a frame, 1 payload byte,
//  2 CRC bytes at frame end. Plain mid-frame payload bytes thus pass one
//  transaction per cycle; the next is taken as its predecessor's last byte leaves.
//  Reset (synchronous, active high) empties the holding and output registers
//  and clears the CRC and frame state. A stall on rsp holds the output byte
//  and backs up into req_stall once the held transaction cannot advance.
// ----------------------------------------------------------------------------
module command_frame_builder_crc16_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cfbc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cfbc_pkg::rsp_type rsp_data
);

   cfbc_pkg::req_type          item_ff, item_in;
   logic                       busy_ff, busy_in;
   logic [cfbc_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                       frame_open_ff, frame_open_in;
   logic [15:0]                crc_ff, crc_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   cfbc_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   cfbc_pkg::seq_type          seq;
   logic                       advance;
   logic                       done;
   logic                       accept;
   logic [cfbc_pkg::POS_W-1:0] first_pos;

   cfbc_byte_seq u_seq (
      .pos  (pos_ff),
      .item (item_ff),
      .crc  (crc_ff),
      .seq  (seq)
   );

   always_comb begin
      advance = busy_ff && (!rsp_valid_ff || !rsp_stall);
      done    = advance && seq.last;
      req_stall = busy_ff && !done;
      accept  = req_valid && !req_stall;

      if (!frame_open_ff) begin
         first_pos = cfbc_pkg::POS_HDR0;
      end else if (req_data.no_payload) begin
         first_pos = cfbc_pkg::POS_CRC_HI;
      end else begin
         first_pos = cfbc_pkg::POS_PAYLOAD;
      end

      item_in       = accept ? req_data : item_ff;
      busy_in       = accept ? 1'b1 : (done ? 1'b0 : busy_ff);
      pos_in        = accept ? first_pos : (advance ? seq.next_pos : pos_ff);
      // frame state is set per transaction; the header is decided at accept time
      frame_open_in = accept ? !(req_data.no_payload | req_data.frame_last) : frame_open_ff;

      crc_in = crc_ff;
      if (advance) begin
         if (pos_ff == cfbc_pkg::POS_HDR0 || seq.frame_end) begin
            crc_in = cfbc_pkg::CRC_INIT;
         end else if (seq.crc_en) begin
            crc_in = cfbc_pkg::crc_byte(crc_ff, seq.out_byte);
         end
      end

      rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_data_in.out_byte  = seq.out_byte;
         rsp_data_in.run_last  = seq.last;
         rsp_data_in.frame_end = seq.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         pos_ff        <= cfbc_pkg::POS_HDR0;
         frame_open_ff <= 1'b0;
         crc_ff        <= cfbc_pkg::CRC_INIT;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         pos_ff        <= pos_in;
         frame_open_ff <= frame_open_in;
         crc_ff        <= crc_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Nothing held means input is never back-pressured.
   assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> !req_stall)
      else $error("req_stall raised with no transaction held");

   // A transaction opening a frame starts at the header start byte.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !frame_open_ff) |=> (pos_ff == cfbc_pkg::POS_HDR0))
      else $error("new frame did not start at header");

   // Between frames the CRC must be back at its initial value.
   assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && !frame_open_ff) |-> (crc_ff == cfbc_pkg::CRC_INIT))
      else $error("CRC not cleared between frames");

   // The frame-ending byte is always the last byte of its transaction.
   assert property (@(posedge clock) disable iff (reset)
      (advance && seq.frame_end) |=> (rsp_data.run_last && !busy_ff) || busy_ff)
      else $error("frame end not marked as transaction end");

endmodule
